@@ design/tdpu_pkg.sv @@
package tdpu_pkg;

    // Low register file geometry
    localparam int NUM_REGS = 8;
    localparam int REG_W    = 32;
    localparam int REG_AW   = 3;

    // Result item, packed onto m_axis_tdata
    localparam int OUT_TDATA_W = 48;
    localparam int IN_TDATA_W  = 16;

    // Shifter kinds (format 1 op field uses the first three codes)
    typedef enum logic [1:0] {
        SH_LSL = 2'd0,
        SH_LSR = 2'd1,
        SH_ASR = 2'd2,
        SH_ROR = 2'd3
    } shift_kind_t;

    // Format 3 opcodes
    localparam logic [1:0] F3_MOV = 2'd0;
    localparam logic [1:0] F3_CMP = 2'd1;
    localparam logic [1:0] F3_ADD = 2'd2;
    localparam logic [1:0] F3_SUB = 2'd3;

    // Format 4 register ALU opcodes
    localparam logic [3:0] ALU_AND = 4'h0;
    localparam logic [3:0] ALU_EOR = 4'h1;
    localparam logic [3:0] ALU_LSL = 4'h2;
    localparam logic [3:0] ALU_LSR = 4'h3;
    localparam logic [3:0] ALU_ASR = 4'h4;
    localparam logic [3:0] ALU_ADC = 4'h5;
    localparam logic [3:0] ALU_SBC = 4'h6;
    localparam logic [3:0] ALU_ROR = 4'h7;
    localparam logic [3:0] ALU_TST = 4'h8;
    localparam logic [3:0] ALU_NEG = 4'h9;
    localparam logic [3:0] ALU_CMP = 4'hA;
    localparam logic [3:0] ALU_CMN = 4'hB;
    localparam logic [3:0] ALU_ORR = 4'hC;
    localparam logic [3:0] ALU_MUL = 4'hD;
    localparam logic [3:0] ALU_BIC = 4'hE;
    localparam logic [3:0] ALU_MVN = 4'hF;

    // Format detection on the top instruction bits
    localparam logic [4:0] F2_PREFIX = 5'b00011;
    localparam logic [2:0] F1_PREFIX = 3'b000;
    localparam logic [2:0] F3_PREFIX = 3'b001;
    localparam logic [5:0] F4_PREFIX = 6'b010000;

    typedef struct packed {
        logic n;
        logic z;
        logic c;
        logic v;
    } flags_t;

    typedef struct packed {
        logic                handled;
        logic                write_enable;
        logic [REG_AW-1:0]   dest_index;
        logic [REG_W-1:0]    result_value;
        flags_t              flags;
    } exec_result_t;

endpackage

@@ design/tdpu_ram.sv @@
module tdpu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

@@ design/tdpu_alu.sv @@
module tdpu_alu (
    input  logic [15:0]                  instr,
    input  logic [tdpu_pkg::REG_W-1:0]   op_a,
    input  logic [tdpu_pkg::REG_W-1:0]   op_b,
    input  tdpu_pkg::flags_t             flags_in,
    output tdpu_pkg::exec_result_t       result
);

    import tdpu_pkg::*;

    // Barrel shifter, returns {carry, value}
    function automatic logic [32:0] barrel(input shift_kind_t kind, input logic [31:0] x,
                                           input logic [7:0] n, input logic cin);
        logic [32:0] t;
        logic [63:0] w;
        logic [32:0] r;
        logic        lt;
        logic        is32;
        lt   = (n < 8'd32);
        is32 = (n == 8'd32);
        r    = {cin, x};
        w    = '0;
        t    = '0;
        if (n != 8'd0)
        begin
            case (kind)
                SH_LSL:
                begin
                    if (lt)
                    begin
                        t = {1'b0, x} << n[4:0];
                        r = t;
                    end
                    else
                    begin
                        r = {is32 & x[0], 32'd0};
                    end
                end
                SH_LSR:
                begin
                    if (lt)
                    begin
                        t = {x, 1'b0} >> n[4:0];
                        r = {t[0], t[32:1]};
                    end
                    else
                    begin
                        r = {is32 & x[31], 32'd0};
                    end
                end
                SH_ASR:
                begin
                    if (lt)
                    begin
                        t = $signed({x, 1'b0}) >>> n[4:0];
                        r = {t[0], t[32:1]};
                    end
                    else
                    begin
                        r = {x[31], {32{x[31]}}};
                    end
                end
                SH_ROR:
                begin
                    w = {x, x} >> n[4:0];
                    r = {w[31], w[31:0]};
                end
                default:
                begin
                    r = {cin, x};
                end
            endcase
        end
        return r;
    endfunction

    logic        is_f1, is_f2, is_f3, is_f4;
    logic [1:0]  f3_op;
    logic [3:0]  f4_op;
    logic [31:0] imm8;
    logic [31:0] f2_b;

    shift_kind_t sh_kind;
    logic [7:0]  sh_n;
    logic [32:0] sh_out;
    logic [31:0] add_x, add_y;
    logic        add_c;
    logic [32:0] sum;
    logic        add_v;
    logic [31:0] prod;

    // Format decode
    assign is_f2 = (instr[15:11] == F2_PREFIX);
    assign is_f1 = (instr[15:13] == F1_PREFIX) && !is_f2;
    assign is_f3 = (instr[15:13] == F3_PREFIX);
    assign is_f4 = (instr[15:10] == F4_PREFIX);
    assign f3_op = instr[12:11];
    assign f4_op = instr[9:6];
    assign imm8  = {24'd0, instr[7:0]};
    assign f2_b  = instr[10] ? {29'd0, instr[8:6]} : op_b;

    // Operand selection for the shared shifter and adder
    always_comb
    begin
        sh_kind = SH_LSL;
        sh_n    = 8'd0;
        add_x   = op_a;
        add_y   = op_b;
        add_c   = 1'b0;
        if (is_f2)
        begin
            add_y = instr[9] ? ~f2_b : f2_b;
            add_c = instr[9];
        end
        else if (is_f1)
        begin
            sh_kind = shift_kind_t'(instr[12:11]);
            if (instr[10:6] == 5'd0 && instr[12:11] != SH_LSL)
            begin
                sh_n = 8'd32;
            end
            else
            begin
                sh_n = {3'd0, instr[10:6]};
            end
        end
        else if (is_f3)
        begin
            add_y = (f3_op == F3_ADD) ? imm8 : ~imm8;
            add_c = (f3_op != F3_ADD);
        end
        else if (is_f4)
        begin
            sh_n = op_b[7:0];
            case (f4_op)
                ALU_LSL: sh_kind = SH_LSL;
                ALU_LSR: sh_kind = SH_LSR;
                ALU_ASR: sh_kind = SH_ASR;
                ALU_ROR: sh_kind = SH_ROR;
                ALU_ADC: add_c = flags_in.c;
                ALU_SBC:
                begin
                    add_y = ~op_b;
                    add_c = flags_in.c;
                end
                ALU_NEG:
                begin
                    add_x = 32'd0;
                    add_y = ~op_b;
                    add_c = 1'b1;
                end
                ALU_CMP:
                begin
                    add_y = ~op_b;
                    add_c = 1'b1;
                end
                default: sh_kind = SH_LSL;
            endcase
        end
    end

    assign sh_out = barrel(sh_kind, op_a, sh_n, flags_in.c);
    assign sum    = {1'b0, add_x} + {1'b0, add_y} + {32'd0, add_c};
    assign add_v  = (add_x[31] ^ sum[31]) & (add_y[31] ^ sum[31]);
    assign prod   = op_a * op_b;

    // Result and flag selection
    always_comb
    begin
        logic use_add;
        logic use_sh;
        logic [31:0] val;
        use_add = 1'b0;
        use_sh  = 1'b0;
        val     = 32'd0;
        result.handled      = 1'b1;
        result.write_enable = 1'b1;
        result.dest_index   = instr[2:0];
        if (is_f2)
        begin
            use_add = 1'b1;
        end
        else if (is_f1)
        begin
            use_sh = 1'b1;
        end
        else if (is_f3)
        begin
            result.dest_index = instr[10:8];
            if (f3_op == F3_MOV)
            begin
                val = imm8;
            end
            else
            begin
                use_add = 1'b1;
            end
            if (f3_op == F3_CMP)
            begin
                result.write_enable = 1'b0;
            end
        end
        else if (is_f4)
        begin
            case (f4_op)
                ALU_AND, ALU_TST: val = op_a & op_b;
                ALU_EOR:          val = op_a ^ op_b;
                ALU_ORR:          val = op_a | op_b;
                ALU_MUL:          val = prod;
                ALU_BIC:          val = op_a & ~op_b;
                ALU_MVN:          val = ~op_b;
                ALU_LSL, ALU_LSR, ALU_ASR, ALU_ROR: use_sh = 1'b1;
                default:          use_add = 1'b1;
            endcase
            if (f4_op == ALU_TST || f4_op == ALU_CMP || f4_op == ALU_CMN)
            begin
                result.write_enable = 1'b0;
            end
        end
        else
        begin
            result.handled      = 1'b0;
            result.write_enable = 1'b0;
            result.dest_index   = '0;
        end

        if (use_add)
        begin
            val = sum[31:0];
        end
        else if (use_sh)
        begin
            val = sh_out[31:0];
        end

        result.result_value = val;
        result.flags        = flags_in;
        if (result.handled)
        begin
            result.flags.n = val[31];
            result.flags.z = (val == 32'd0);
            if (use_add)
            begin
                result.flags.c = sum[32];
                result.flags.v = add_v;
            end
            else if (use_sh)
            begin
                result.flags.c = sh_out[32];
            end
        end
    end

endmodule

@@ design/thumb_data_processing_unit.sv @@
// Thumb data-processing execute unit (formats 1 to 4).
// Input channel s_axis_*: one 16-bit Thumb instruction per item.
// Output channel m_axis_*: one result item per instruction: handled flag,
// write enable, destination index, 32-bit value and the N, Z, C, V flags
// after the instruction. Unhandled encodings give a zero value and index and
// report the current flags without changing any state.
// The instruction register loads at the accepting edge, and the result register
// loads when the instruction advances; m_axis_tvalid then shows the result.
// Throughput: one item per cycle while the receiver takes the results; the
// operand read of the eight-entry register file is issued as the item is
// accepted and forwarded from the write of the item ahead of it.
// Reset clears the register file (per-entry valid bits) and the flags, and
// empties both stages. A stalled receiver holds the result register; one
// more item may wait in the instruction register, after which s_axis_tready
// drops until the result is taken. The register file and flags change only
// when an instruction moves into the result register.
module thumb_data_processing_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] instruction
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] handled, [1] write_enable, [4:2] dest_index, [36:5] result_value,
    // [37] flag_negative, [38] flag_zero, [39] flag_carry, [40] flag_overflow
    output logic [tdpu_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    import tdpu_pkg::*;

    logic                  accept;
    logic                  advance;
    logic                  in_valid_reg;
    logic [15:0]           instr_reg;
    logic                  in_f3, in_f4;
    logic [REG_AW-1:0]     raddr_a, raddr_b;
    logic                  a_byp_reg, b_byp_reg;
    logic                  a_vld_reg, b_vld_reg;
    logic [REG_W-1:0]      fwd_data_reg;
    logic [REG_W-1:0]      ram_qa, ram_qb;
    logic [REG_W-1:0]      op_a, op_b;
    logic [NUM_REGS-1:0]   rf_valid_reg;
    logic                  rf_we;
    flags_t                flags_reg;
    exec_result_t          exec_res;
    logic                  out_valid_reg;
    exec_result_t          out_reg;

    // Handshake and stage advance
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign rf_we         = advance && exec_res.handled && exec_res.write_enable;

    // Register file read addresses from the incoming instruction
    assign in_f3   = (s_axis_tdata[15:13] == F3_PREFIX);
    assign in_f4   = (s_axis_tdata[15:10] == F4_PREFIX);
    assign raddr_a = in_f3 ? s_axis_tdata[10:8] :
                     (in_f4 ? s_axis_tdata[2:0] : s_axis_tdata[5:3]);
    assign raddr_b = in_f4 ? s_axis_tdata[5:3] : s_axis_tdata[8:6];

    tdpu_ram #(
        .WIDTH (REG_W),
        .DEPTH (NUM_REGS)
    ) u_regfile (
        .clk     (clk),
        .we      (rf_we),
        .waddr   (exec_res.dest_index),
        .wdata   (exec_res.result_value),
        .re      (accept),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (ram_qa),
        .rdata_b (ram_qb)
    );

    // Instruction stage control and operand forwarding flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            a_byp_reg    <= 1'b0;
            b_byp_reg    <= 1'b0;
            a_vld_reg    <= 1'b0;
            b_vld_reg    <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                in_valid_reg <= 1'b1;
                a_byp_reg    <= rf_we && (exec_res.dest_index == raddr_a);
                b_byp_reg    <= rf_we && (exec_res.dest_index == raddr_b);
                a_vld_reg    <= rf_valid_reg[raddr_a];
                b_vld_reg    <= rf_valid_reg[raddr_b];
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
        end
    end

    // Instruction stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            instr_reg    <= s_axis_tdata;
            fwd_data_reg <= exec_res.result_value;
        end
    end

    assign op_a = a_byp_reg ? fwd_data_reg : (a_vld_reg ? ram_qa : '0);
    assign op_b = b_byp_reg ? fwd_data_reg : (b_vld_reg ? ram_qb : '0);

    tdpu_alu u_alu (
        .instr    (instr_reg),
        .op_a     (op_a),
        .op_b     (op_b),
        .flags_in (flags_reg),
        .result   (exec_res)
    );

    // Architectural state: flags and register valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg    <= '0;
            rf_valid_reg <= '0;
        end
        else
        begin
            if (advance && exec_res.handled)
            begin
                flags_reg <= exec_res.flags;
            end
            if (rf_we)
            begin
                rf_valid_reg[exec_res.dest_index] <= 1'b1;
            end
        end
    end

    // Result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= exec_res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0,
                            out_reg.flags.v, out_reg.flags.c,
                            out_reg.flags.z, out_reg.flags.n,
                            out_reg.result_value, out_reg.dest_index,
                            out_reg.write_enable, out_reg.handled};

`ifndef NO_ASSERTIONS
    a_unhandled_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !exec_res.handled |-> !rf_we)
        else $error("unhandled instruction writes the register file");

    a_flags_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(flags_reg))
        else $error("flags changed without an instruction retiring");

    a_valid_bits_grow: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ((rf_valid_reg & $past(rf_valid_reg)) == $past(rf_valid_reg)))
        else $error("register valid bit cleared after reset");

    a_full_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_valid_reg && !m_axis_tready |-> !s_axis_tready)
        else $error("item accepted while both stages are full and stalled");

    a_retire_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_axis_tvalid)
        else $error("retired instruction produced no result item");
`endif

endmodule
